@@ sv/ffba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, codes and default sizes of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  // field widths of the request and response beats
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned SIZE_W   = 21;
  localparam int unsigned ADDR_W   = 21;
  localparam int unsigned STATUS_W = 3;

  // packed stream widths, rounded up to whole bytes
  localparam int unsigned REQ_BITS  = MODE_W + SIZE_W + ADDR_W;
  localparam int unsigned REQ_W     = ((REQ_BITS + 7) / 8) * 8;
  localparam int unsigned RSP_BITS  = STATUS_W + ADDR_W + 1 + ADDR_W + SIZE_W;
  localparam int unsigned RSP_W     = ((RSP_BITS + 7) / 8) * 8;

  // default configuration
  localparam int unsigned DEF_HEAP_BYTES   = 1024 * 1024;
  localparam int unsigned DEF_MAX_BLOCKS   = 64;
  localparam int unsigned DEF_HEADER_BYTES = 12;

  // request kinds
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_REALLOC = 2'd2,
    MODE_SPARE   = 2'd3
  } mode_t;

  // response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOMEM    = 3'd1,
    ST_ZERO     = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_DOUBLE   = 3'd5
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_FIT,
    S_WR_NEW,
    S_WR_OLD,
    S_DONE
  } state_t;

endpackage

@@ sv/first_fit_block_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap allocator with a block table held in one synchronous memory.
// ----------------------------------------------------------------------------
// One request beat (allocate, free or reallocate) gives one response beat.
// The block table sits in a single memory with one read and one write port;
// a lookup walks the table one entry per cycle through the read port, so the
// block count sets the time per request. A reallocate that moves its block
// walks the table twice. Null frees and zero-size allocates skip the walk and
// go from idle straight to the done state. The sequencer returns to idle
// before it takes the next request beat, so a request is not taken until the
// previous one has been answered. The table needs no clearing after reset:
// only entries below the block count are ever read. A new request is taken
// while the previous response still waits at the output.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
  parameter int unsigned HEAP_BYTES   = ffba_pkg::DEF_HEAP_BYTES,
  parameter int unsigned MAX_BLOCKS   = ffba_pkg::DEF_MAX_BLOCKS,
  parameter int unsigned HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES
) (
  input  logic                       clk,
  input  logic                       rst,
  // request: mode[1:0], request_size[22:2], payload_address[43:23]
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [ffba_pkg::REQ_W-1:0] s_tdata,
  // response: status[2:0], result_address[23:3], copy_needed[24],
  //           copy_source[45:25], copy_bytes[66:46]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [ffba_pkg::RSP_W-1:0] m_tdata
);
  import ffba_pkg::*;

  localparam int unsigned TOP_W  = $clog2(HEAP_BYTES + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
  localparam int unsigned WIDE_W = (TOP_W > SIZE_W) ? TOP_W : SIZE_W;
  localparam int unsigned SUM_W  = WIDE_W + 2;
  localparam int unsigned WORD_W = 1 + SIZE_W + TOP_W;

  localparam logic [SUM_W-1:0] HDR   = SUM_W'(HEADER_BYTES);
  localparam logic [SUM_W-1:0] LIMIT = SUM_W'(HEAP_BYTES);
  localparam logic [CNT_W-1:0] FULL  = CNT_W'(MAX_BLOCKS);

  // request fields
  mode_t             in_mode;
  logic [SIZE_W-1:0] in_size;
  logic [ADDR_W-1:0] in_addr;
  logic              in_alloc;

  assign in_mode  = mode_t'(s_tdata[MODE_W-1:0]);
  assign in_size  = s_tdata[MODE_W +: SIZE_W];
  assign in_addr  = s_tdata[MODE_W+SIZE_W +: ADDR_W];
  assign in_alloc = (in_mode == MODE_ALLOC) ||
                    ((in_mode == MODE_REALLOC) && (in_addr == '0));

  // control and datapath registers
  state_t            state, state_next;
  logic [CNT_W-1:0]  entry_count;
  logic [TOP_W-1:0]  heap_top;
  logic              is_realloc;
  logic              is_move;
  logic [SIZE_W-1:0] req_size;
  logic [ADDR_W-1:0] req_addr;
  logic [CNT_W-1:0]  rd_idx;
  logic              chk_vld;
  logic [IDX_W-1:0]  chk_idx;
  logic [IDX_W-1:0]  old_idx, new_idx;
  logic [TOP_W-1:0]  old_start, new_start;
  logic [SIZE_W-1:0] old_size, new_size;
  status_t           res_status;
  logic [ADDR_W-1:0] res_addr;
  logic              res_copy;
  logic [ADDR_W-1:0] res_src;
  logic [SIZE_W-1:0] res_bytes;
  logic [RSP_W-1:0]  out_data;

  // block table
  logic [WORD_W-1:0] table_mem [MAX_BLOCKS];
  logic [WORD_W-1:0] rd_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  // fields of the entry under test
  logic [TOP_W-1:0]  rd_start;
  logic [SIZE_W-1:0] rd_size;
  logic              rd_used;
  logic [SUM_W-1:0]  rd_payload;
  logic              find_hit, fit_hit, scan_end;
  logic [SUM_W-1:0]  append_end;
  logic              append_ok, append_room;
  logic              out_free;

  assign rd_start   = rd_data[TOP_W-1:0];
  assign rd_size    = rd_data[TOP_W +: SIZE_W];
  assign rd_used    = rd_data[WORD_W-1];
  assign rd_payload = SUM_W'(rd_start) + HDR;
  assign find_hit   = chk_vld && (rd_payload == SUM_W'(req_addr));
  assign fit_hit    = chk_vld && !rd_used && (rd_size >= req_size);
  assign scan_end   = !chk_vld && (rd_idx >= entry_count);
  assign append_end = SUM_W'(heap_top) + HDR + SUM_W'(req_size);
  assign append_room = append_end <= LIMIT;
  assign append_ok  = append_room && (entry_count < FULL);
  assign out_free   = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (in_alloc) begin
            state_next = (in_size == '0) ? S_DONE : S_FIT;
          end else if ((in_mode == MODE_REALLOC) || (in_addr != '0)) begin
            state_next = S_FIND;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_FIND: begin
        if (find_hit) begin
          if (!rd_used) begin
            state_next = S_DONE;
          end else if (!is_realloc) begin
            state_next = S_WR_OLD;
          end else if (rd_size >= req_size) begin
            state_next = S_DONE;
          end else begin
            state_next = S_FIT;
          end
        end else if (scan_end) begin
          state_next = S_DONE;
        end
      end
      S_FIT: begin
        if (fit_hit) begin
          state_next = S_WR_NEW;
        end else if (scan_end) begin
          state_next = append_ok ? S_WR_NEW : S_DONE;
        end
      end
      S_WR_NEW: state_next = is_move ? S_WR_OLD : S_DONE;
      S_WR_OLD: state_next = S_DONE;
      S_DONE:   state_next = out_free ? S_IDLE : S_DONE;
      default:  state_next = S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    rd_en     = ((state == S_FIND) || (state == S_FIT)) && (rd_idx < entry_count);
    rd_addr   = rd_idx[IDX_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = new_idx;
    mem_wdata = {1'b1, new_size, new_start};
    unique case (state)
      S_WR_NEW: mem_we = 1'b1;
      S_WR_OLD: begin
        mem_we    = 1'b1;
        mem_waddr = old_idx;
        mem_wdata = {1'b0, old_size, old_start};
      end
      default: mem_we = 1'b0;
    endcase
  end

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= table_mem[rd_addr];
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      heap_top    <= '0;
      rd_idx      <= '0;
      chk_vld     <= 1'b0;
      is_move     <= 1'b0;
    end else begin
      state <= state_next;

      // table walk: one read issued per cycle, checked in the next cycle
      if (state_next != state) begin
        rd_idx  <= '0;
        chk_vld <= 1'b0;
      end else if (rd_en) begin
        rd_idx  <= rd_idx + CNT_W'(1);
        chk_idx <= rd_idx[IDX_W-1:0];
        chk_vld <= 1'b1;
      end else begin
        chk_vld <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            is_realloc <= (in_mode == MODE_REALLOC) && !in_alloc;
            is_move    <= 1'b0;
            req_size   <= in_size;
            req_addr   <= in_addr;
            res_status <= (in_alloc && (in_size == '0)) ? ST_ZERO : ST_OK;
            res_addr   <= '0;
            res_copy   <= 1'b0;
            res_src    <= '0;
            res_bytes  <= '0;
          end
        end
        S_FIND: begin
          if (find_hit) begin
            old_idx   <= chk_idx;
            old_start <= rd_start;
            old_size  <= rd_size;
            if (!rd_used) begin
              res_status <= ST_DOUBLE;
            end else if (is_realloc && (rd_size >= req_size)) begin
              res_addr <= req_addr;
            end else if (is_realloc) begin
              is_move <= 1'b1;
            end
          end else if (scan_end) begin
            res_status <= ST_NOTFOUND;
          end
        end
        S_FIT: begin
          if (fit_hit) begin
            new_idx   <= chk_idx;
            new_start <= rd_start;
            new_size  <= rd_size;
            res_addr  <= rd_payload[ADDR_W-1:0];
          end else if (scan_end) begin
            if (!append_room) begin
              res_status <= ST_NOMEM;
            end else if (!append_ok) begin
              res_status <= ST_FULL;
            end else begin
              new_idx     <= entry_count[IDX_W-1:0];
              new_start   <= heap_top;
              new_size    <= req_size;
              res_addr    <= ADDR_W'(SUM_W'(heap_top) + HDR);
              heap_top    <= append_end[TOP_W-1:0];
              entry_count <= entry_count + CNT_W'(1);
            end
          end
        end
        S_WR_OLD: begin
          if (is_move) begin
            res_copy  <= 1'b1;
            res_src   <= req_addr;
            res_bytes <= old_size;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register, loaded as the sequencer finishes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      m_tvalid <= 1'b1;
      out_data <= RSP_W'({res_bytes, res_src, res_copy, res_addr, res_status});
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = out_data;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= FULL)
    else $error("block count beyond table depth");

  a_heap_bound: assert property (@(posedge clk) disable iff (rst)
    SUM_W'(heap_top) <= LIMIT)
    else $error("bump pointer beyond heap");

  a_fail_null: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[STATUS_W-1:0] != ST_OK)) |->
      (m_tdata[STATUS_W +: ADDR_W] == '0) && !m_tdata[STATUS_W+ADDR_W])
    else $error("failed request returned an address or a copy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("sequencer did not leave idle after a request beat");

  a_move_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR_OLD) |=> (state == S_DONE))
    else $error("old block write not followed by the response");

endmodule
